// ===== design/pme_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Playfield majority encoder package
// Shared types, row geometry and per-write segment tables.
// ----------------------------------------------------------------------------
package pme_pkg;

  localparam int unsigned ROW_PIXELS   = 160;
  localparam int unsigned IDX_W        = 8;
  localparam int unsigned GROUP_W      = 6;
  localparam int unsigned CNT_W        = 3;
  localparam int unsigned SEG_W        = 3;

  localparam logic [CNT_W-1:0] MAJORITY_MIN  = 3'd3;
  localparam logic [IDX_W-1:0] LAST_PIXEL    = 8'(ROW_PIXELS - 1);
  localparam logic [SEG_W-1:0] SEG_ROW_LAST  = 3'd5;

  // Playfield register codes
  typedef enum logic [1:0] {
    REG_PF0 = 2'd0,
    REG_PF1 = 2'd1,
    REG_PF2 = 2'd2
  } pf_reg_t;

  // Group status handed from the accumulator to the packer
  typedef struct packed {
    logic               write_due;    // this word closes a register write
    logic               group_end;    // this word completes a group
    logic               filled;       // majority of group matches fill class
    logic [CNT_W-1:0]   group_match;  // matched pixels of group after fill
    logic [SEG_W-1:0]   seg;          // write segment of current group
  } group_status_t;

  // Segment holding a group
  function automatic logic [SEG_W-1:0] seg_of(input logic [GROUP_W-1:0] group);
    logic [SEG_W-1:0] s;
    if (group <= 6'd3)       s = 3'd0;
    else if (group <= 6'd11) s = 3'd1;
    else if (group <= 6'd19) s = 3'd2;
    else if (group <= 6'd23) s = 3'd3;
    else if (group <= 6'd31) s = 3'd4;
    else                     s = 3'd5;
    return s;
  endfunction

  function automatic logic [GROUP_W-1:0] seg_last_group(input logic [SEG_W-1:0] s);
    logic [GROUP_W-1:0] g;
    unique case (s)
      3'd0:    g = 6'd3;
      3'd1:    g = 6'd11;
      3'd2:    g = 6'd19;
      3'd3:    g = 6'd23;
      3'd4:    g = 6'd31;
      default: g = 6'd39;
    endcase
    return g;
  endfunction

  function automatic pf_reg_t seg_reg(input logic [SEG_W-1:0] s);
    pf_reg_t r;
    unique case (s) inside
      3'd0, 3'd3: r = REG_PF0;
      3'd1, 3'd4: r = REG_PF1;
      default:    r = REG_PF2;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] seg_start_ofs(input logic [SEG_W-1:0] s);
    logic [7:0] o;
    unique case (s)
      3'd0:    o = 8'd68;
      3'd1:    o = 8'd84;
      3'd2:    o = 8'd116;
      3'd3:    o = 8'd148;
      3'd4:    o = 8'd164;
      default: o = 8'd196;
    endcase
    return o;
  endfunction

  function automatic logic [7:0] seg_end_ofs(input logic [SEG_W-1:0] s);
    logic [7:0] o;
    unique case (s)
      3'd0:    o = 8'd84;
      3'd1:    o = 8'd116;
      3'd2:    o = 8'd148;
      3'd3:    o = 8'd164;
      3'd4:    o = 8'd196;
      default: o = 8'd228;
    endcase
    return o;
  endfunction

endpackage

// ===== design/pme_group_accum.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Playfield majority encoder group accumulator
// Tracks pixel position and per-group class counts; reports group result.
// ----------------------------------------------------------------------------
module pme_group_accum (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic [7:0]                   pixel_class,
  input  logic [7:0]                   target_class,
  input  logic [7:0]                   fill_class,
  output pme_pkg::group_status_t       status
);

  logic [pme_pkg::IDX_W-1:0]   pixel_index;
  logic [pme_pkg::CNT_W-1:0]   group_fill_count;
  logic [pme_pkg::CNT_W-1:0]   group_match_if_filled;
  logic [pme_pkg::CNT_W-1:0]   group_match_if_kept;

  logic [pme_pkg::CNT_W-1:0]   fill_count_next;
  logic [pme_pkg::CNT_W-1:0]   match_filled_next;
  logic [pme_pkg::CNT_W-1:0]   match_kept_next;
  logic [pme_pkg::GROUP_W-1:0] group;
  logic                        group_end;

  assign group     = pixel_index[pme_pkg::IDX_W-1:2];
  assign group_end = (pixel_index[1:0] == 2'd3);

  assign fill_count_next   = group_fill_count + pme_pkg::CNT_W'(pixel_class == fill_class);
  assign match_filled_next = group_match_if_filled + pme_pkg::CNT_W'(target_class == fill_class);
  assign match_kept_next   = group_match_if_kept + pme_pkg::CNT_W'(pixel_class == target_class);

  always_comb begin
    status.seg         = pme_pkg::seg_of(group);
    status.group_end   = group_end;
    status.write_due   = group_end && (group == pme_pkg::seg_last_group(status.seg));
    status.filled      = (fill_count_next >= pme_pkg::MAJORITY_MIN);
    status.group_match = status.filled ? match_filled_next : match_kept_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_index           <= '0;
      group_fill_count      <= '0;
      group_match_if_filled <= '0;
      group_match_if_kept   <= '0;
    end else if (accept) begin
      pixel_index <= (pixel_index == pme_pkg::LAST_PIXEL) ? '0 : pixel_index + 8'd1;
      if (group_end) begin
        group_fill_count      <= '0;
        group_match_if_filled <= '0;
        group_match_if_kept   <= '0;
      end else begin
        group_fill_count      <= fill_count_next;
        group_match_if_filled <= match_filled_next;
        group_match_if_kept   <= match_kept_next;
      end
    end
  end

  a_index_in_row: assert property (@(posedge clk) disable iff (rst)
    pixel_index <= pme_pkg::LAST_PIXEL)
    else $error("pixel index beyond row");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    group_fill_count <= 3'd3 && group_match_if_kept <= 3'd3)
    else $error("group count beyond three pixels");

  a_wrap: assert property (@(posedge clk) disable iff (rst)
    accept && pixel_index == pme_pkg::LAST_PIXEL |=> pixel_index == '0)
    else $error("row did not wrap");

endmodule

// ===== design/playfield_majority_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Playfield majority encoder
// Folds a 160-pixel row into six playfield register writes by 4-pixel
// majority, and counts pixels matching their target after filling.
// ----------------------------------------------------------------------------
// Output: a write is registered and appears in the cycle after the pixel closing it.
// Throughput: one pixel word per cycle; input is stalled only when the word
//   would close a write while the previous write is still held downstream.
// Reset (rst, synchronous): row position, group counts, pattern, row total,
//   fill_class and the output valid flag clear; no clearing pass.
// ----------------------------------------------------------------------------
module playfield_majority_encoder (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_write_enable,
  input  logic [7:0]  cfg_write_data,
  // pixel words
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  pixel_class,
  input  logic [7:0]  target_class,
  input  logic [15:0] line_time,
  // register write words
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  reg_select,
  output logic [7:0]  reg_value,
  output logic [16:0] start_time,
  output logic [16:0] end_time,
  output logic [7:0]  pixels_matched,
  output logic        row_done
);

  logic [7:0]             fill_class;
  logic [7:0]             pattern_byte;
  logic [7:0]             row_match_total;

  logic                   accept;
  logic                   row_last;
  pme_pkg::group_status_t status;
  pme_pkg::pf_reg_t       seg_reg;
  logic [7:0]             pattern_next;
  logic [7:0]             total_next;

  // Fill class register; the user must write it only between words, the block does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_class <= '0;
    end else if (cfg_write_enable) begin
      fill_class <= cfg_write_data;
    end
  end

  // Hold off only the word that would produce a result into a full,
  // stalled output register; words inside a group flow regardless.
  assign in_stall = out_valid && out_stall && status.write_due;
  assign accept   = in_valid && !in_stall;

  pme_group_accum u_group_accum (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .pixel_class  (pixel_class),
    .target_class (target_class),
    .fill_class   (fill_class),
    .status       (status)
  );

  assign seg_reg  = pme_pkg::seg_reg(status.seg);
  assign row_last = (status.seg == pme_pkg::SEG_ROW_LAST);

  // PF1 shifts in at D0; PF0 and PF2 shift in at D7
  always_comb begin
    if (seg_reg == pme_pkg::REG_PF1) begin
      pattern_next = {pattern_byte[6:0], status.filled};
    end else begin
      pattern_next = {status.filled, pattern_byte[7:1]};
    end
  end

  assign total_next = row_match_total + 8'(status.group_match);

  // Pattern and row total; both clear after each write / at row end
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_byte    <= '0;
      row_match_total <= '0;
    end else if (accept && status.group_end) begin
      pattern_byte    <= status.write_due ? '0 : pattern_next;
      row_match_total <= (status.write_due && row_last) ? '0 : total_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && status.write_due) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && status.write_due) begin
      reg_select     <= seg_reg;
      reg_value      <= pattern_next;
      start_time     <= {1'b0, line_time} + 17'(pme_pkg::seg_start_ofs(status.seg));
      end_time       <= {1'b0, line_time} + 17'(pme_pkg::seg_end_ofs(status.seg));
      pixels_matched <= row_last ? total_next : '0;
      row_done       <= row_last;
    end
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with free output");

  a_row_done_pf2: assert property (@(posedge clk) disable iff (rst)
    out_valid && row_done |-> reg_select == pme_pkg::REG_PF2)
    else $error("row end on wrong register");

  a_matched_only_at_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !row_done |-> pixels_matched == 8'd0)
    else $error("match count outside row end");

  a_matched_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid && row_done |-> pixels_matched <= 8'd160)
    else $error("match count beyond row length");

  a_window: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> end_time > start_time)
    else $error("write window empty");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Playfield majority encoder testbench
// Streams pixel words through the encoder with random gaps and stalls on both
// sides, predicts every playfield write in step with accepted pixels and
// checks each write word field by field in order of arrival.
// ----------------------------------------------------------------------------
module tb;

  // Pixel word as offered on the input channel
  typedef struct packed {
    logic [7:0]  pc;
    logic [7:0]  tc;
    logic [15:0] rt;
  } pixel_word_t;

  // Playfield write word as expected on the output channel
  typedef struct packed {
    pme_pkg::pf_reg_t sel;
    logic [7:0]       value;
    logic [16:0]      t_start;
    logic [16:0]      t_end;
    logic [7:0]       matched;
    logic             done;
  } pf_write_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write_enable = 1'b0;
  logic [7:0]  cfg_write_data = 8'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  pixel_class = 8'd0;
  logic [7:0]  target_class = 8'd0;
  logic [15:0] line_time = 16'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  reg_select;
  logic [7:0]  reg_value;
  logic [16:0] start_time;
  logic [16:0] end_time;
  logic [7:0]  pixels_matched;
  logic        row_done;

  playfield_majority_encoder dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .pixel_class      (pixel_class),
    .target_class     (target_class),
    .line_time        (line_time),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .reg_select       (reg_select),
    .reg_value        (reg_value),
    .start_time       (start_time),
    .end_time         (end_time),
    .pixels_matched   (pixels_matched),
    .row_done         (row_done)
  );

  // 2 ns clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // --------------------------------------------------------------------------
  // Shared state
  // --------------------------------------------------------------------------
  pixel_word_t pending_pixels[$];   // words waiting for the driver
  pf_write_t   pf_writes_due[$];    // predicted writes not yet seen
  int unsigned pixels_queued = 0;
  int unsigned pixels_taken  = 0;
  int unsigned mismatches    = 0;
  logic        pixel_taken   = 1'b0;  // word accepted at the last rising edge
  logic        calm          = 1'b0;  // no idling on either side
  int unsigned hold_requests = 0;     // long receiver hold-offs asked for

  // Predictor copy of the encoder state
  logic [7:0]  fill_cls       = 8'd0;
  logic [7:0]  row_pos        = 8'd0;
  logic [2:0]  grp_fill       = 3'd0;  // pixels equal to the fill class
  logic [2:0]  grp_hit_filled = 3'd0;  // targets equal to the fill class
  logic [2:0]  grp_hit_kept   = 3'd0;  // pixels already equal to target
  logic [7:0]  pf_bits        = 8'd0;
  logic [7:0]  row_hits       = 8'd0;

  // Stimulus generator position and row timing
  int unsigned gen_pos   = 0;
  logic [15:0] gen_row_t = 16'd0;
  logic [3:0]  grp_mask  = 4'd0;
  logic        grp_noise = 1'b0;
  logic [7:0]  cur_fill  = 8'd0;

  function automatic string fmt_write(input pf_write_t w);
    return $sformatf("sel=%0d value=%02h start=%0d end=%0d matched=%0d done=%0d",
                     w.sel, w.value, w.t_start, w.t_end, w.matched, w.done);
  endfunction

  task automatic log_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t ns: %s", $time, msg);
  endtask

  // --------------------------------------------------------------------------
  // Predictor: advance the row by one pixel, queue a write when a segment
  // of groups closes. Segments: groups 0-3 PF0, 4-11 PF1, 12-19 PF2,
  // 20-23 PF0, 24-31 PF1, 32-39 PF2.
  // --------------------------------------------------------------------------
  task automatic fit_pixel(input logic [7:0] pc, input logic [7:0] tc,
                           input logic [15:0] rt);
    logic [5:0]       grp;
    logic             filled;
    logic [5:0]       seg_end_grp;
    pme_pkg::pf_reg_t sel;
    logic [7:0]       ofs_a;
    logic [7:0]       ofs_b;
    logic             last;
    pf_write_t        w;
    if (pc == fill_cls) grp_fill++;
    if (tc == fill_cls) grp_hit_filled++;
    if (pc == tc)       grp_hit_kept++;
    if (row_pos[1:0] == 2'b11) begin
      grp    = row_pos[7:2];
      filled = (grp_fill >= 3'd3);
      row_hits = row_hits + 8'(filled ? grp_hit_filled : grp_hit_kept);
      last = 1'b0;
      if (grp <= 6'd3) begin
        seg_end_grp = 6'd3;  sel = pme_pkg::REG_PF0; ofs_a = 8'd68;  ofs_b = 8'd84;
      end else if (grp <= 6'd11) begin
        seg_end_grp = 6'd11; sel = pme_pkg::REG_PF1; ofs_a = 8'd84;  ofs_b = 8'd116;
      end else if (grp <= 6'd19) begin
        seg_end_grp = 6'd19; sel = pme_pkg::REG_PF2; ofs_a = 8'd116; ofs_b = 8'd148;
      end else if (grp <= 6'd23) begin
        seg_end_grp = 6'd23; sel = pme_pkg::REG_PF0; ofs_a = 8'd148; ofs_b = 8'd164;
      end else if (grp <= 6'd31) begin
        seg_end_grp = 6'd31; sel = pme_pkg::REG_PF1; ofs_a = 8'd164; ofs_b = 8'd196;
      end else begin
        seg_end_grp = 6'd39; sel = pme_pkg::REG_PF2; ofs_a = 8'd196; ofs_b = 8'd228;
        last = 1'b1;
      end
      // PF1 fills from D0 upwards, PF0 and PF2 from D7 downwards
      if (sel == pme_pkg::REG_PF1)
        pf_bits = {pf_bits[6:0], filled};
      else
        pf_bits = {filled, pf_bits[7:1]};
      grp_fill       = 3'd0;
      grp_hit_filled = 3'd0;
      grp_hit_kept   = 3'd0;
      if (grp == seg_end_grp) begin
        w.sel     = sel;
        w.value   = pf_bits;
        w.t_start = 17'(rt) + 17'(ofs_a);
        w.t_end   = 17'(rt) + 17'(ofs_b);
        w.matched = last ? row_hits : 8'd0;
        w.done    = last;
        pf_writes_due = {pf_writes_due, w};
        pf_bits = 8'd0;
        if (last) row_hits = 8'd0;
      end
    end
    row_pos++;
    if (row_pos >= 8'(pme_pkg::ROW_PIXELS)) begin
      row_pos  = 8'd0;
      row_hits = 8'd0;
      pf_bits  = 8'd0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_pixel(input logic [7:0] pc, input logic [7:0] tc,
                             input logic [15:0] rt);
    pixel_word_t w;
    w.pc = pc;
    w.tc = tc;
    w.rt = rt;
    pending_pixels = {pending_pixels, w};
    pixels_queued++;
    gen_pos = (gen_pos + 1) % pme_pkg::ROW_PIXELS;
  endtask

  // Mostly groups with a random number of fill-class pixels, so that
  // majorities of three and four are common; now and then a fully random
  // group. Row time is held per row but may jump mid-row.
  task automatic queue_random_pixels(input int n);
    logic [7:0] pc;
    logic [7:0] tc;
    int         pick;
    for (int i = 0; i < n; i++) begin
      if (gen_pos == 0) begin
        if ($urandom_range(0, 7) == 0)
          gen_row_t = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        else
          gen_row_t = 16'($urandom);
      end else if ($urandom_range(0, 39) == 0) begin
        gen_row_t = 16'($urandom);
      end
      if (gen_pos % 4 == 0) begin
        grp_mask  = 4'($urandom);
        grp_noise = ($urandom_range(0, 7) == 0);
      end
      if (grp_noise || !grp_mask[gen_pos % 4])
        pc = 8'($urandom);
      else
        pc = cur_fill;
      pick = $urandom_range(0, 2);
      tc = (pick == 0) ? cur_fill : (pick == 1) ? pc : 8'($urandom);
      queue_pixel(pc, tc, gen_row_t);
    end
  endtask

  // Wait until every queued word is taken and every write has come back,
  // then let the output register settle before touching the fill class.
  task automatic wait_idle();
    while (pixels_taken != pixels_queued || pf_writes_due.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Driver: new word at the falling edge once the last one was taken.
  // A stalled word is held as it is.
  // --------------------------------------------------------------------------
  int unsigned src_gap = 0;

  always @(negedge clk) begin
    pixel_word_t w;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || pixel_taken) begin
      if (src_gap != 0) begin
        src_gap--;
        in_valid <= 1'b0;
      end else if (pending_pixels.size() == 0) begin
        in_valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        // random idle gap before the next word
        src_gap = $urandom_range(0, 7);
        in_valid <= 1'b0;
      end else begin
        w = pending_pixels.pop_front();
        pixel_class  <= w.pc;
        target_class <= w.tc;
        line_time    <= w.rt;
        in_valid     <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stall bursts, plus the long hold-off on request so the
  // encoder backs up and stalls its pixel input.
  // --------------------------------------------------------------------------
  int unsigned sink_gap   = 0;
  int unsigned sink_hold  = 0;
  int unsigned holds_done = 0;

  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (sink_hold != 0) begin
      sink_hold--;
      out_stall <= 1'b1;
    end else if (holds_done != hold_requests) begin
      holds_done++;
      sink_hold = 200;
      out_stall <= 1'b1;
    end else if (sink_gap != 0) begin
      sink_gap--;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      sink_gap = $urandom_range(0, 7);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check the write word first, then predict from the pixel word
  // taken at the same edge (its write cannot appear before the next edge).
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    pf_write_t got;
    pf_write_t want;
    if (rst) begin
      pixel_taken <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got.sel     = pme_pkg::pf_reg_t'(reg_select);
        got.value   = reg_value;
        got.t_start = start_time;
        got.t_end   = end_time;
        got.matched = pixels_matched;
        got.done    = row_done;
        if (pf_writes_due.size() == 0) begin
          log_mismatch({"unexpected write word: ", fmt_write(got)});
        end else begin
          want = pf_writes_due.pop_front();
          if (got.sel !== want.sel || got.value !== want.value ||
              got.t_start !== want.t_start || got.t_end !== want.t_end ||
              got.matched !== want.matched || got.done !== want.done)
            log_mismatch({"write word: expected ", fmt_write(want),
                          " / actual ", fmt_write(got)});
        end
      end
      pixel_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        fit_pixel(pixel_class, target_class, line_time);
        pixels_taken++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned g;
    int unsigned j;
    logic [7:0]  new_fill;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // Directed, fill class at its reset value of 0.
    // Groups 0-3 hold four, three, two and one fill pixels: full majority,
    // bare majority, no majority. Row time jumps from 0 to its top value
    // mid-row, so the first PF0 write uses the top value and its times
    // need the 17th bit.
    for (int i = 0; i < 16; i++) begin
      g = i / 4;
      j = i % 4;
      queue_pixel((j < 4 - g) ? 8'h00 : 8'hFF,
                  (i[0] ^ i[2]) ? 8'hFF : 8'h00,
                  (i < 8) ? 16'h0000 : 16'hFFFF);
    end
    // Into PF1 with another row time change
    for (int i = 0; i < 8; i++)
      queue_pixel(i[0] ? 8'h55 : 8'hAA, 8'hAA, 16'h8000);
    wait_idle();

    // Random phases; each opens with a fill class write while idle, and
    // phase ends fall mid-row, so the fill class changes part way through
    // rows too. First two settings are the extremes.
    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0:       new_fill = 8'hFF;
        1:       new_fill = 8'h00;
        default: new_fill = 8'($urandom);
      endcase
      cfg_write_enable <= 1'b1;
      cfg_write_data   <= new_fill;
      @(negedge clk);
      cfg_write_enable <= 1'b0;
      fill_cls = new_fill;
      cur_fill = new_fill;
      // quiet stretch mid-run, and none at all at the tail
      calm = (ph == 5) || (ph >= 10);
      queue_random_pixels($urandom_range(120, 200));
      if (ph == 2) hold_requests++;
      wait_idle();
    end

    repeat (8) @(negedge clk);
    while (pf_writes_due.size() != 0)
      log_mismatch({"write never seen: ", fmt_write(pf_writes_due.pop_front())});
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // Watchdog
  initial begin
    #1000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/pme_pkg.sv
design/pme_group_accum.sv
design/playfield_majority_encoder.sv
dv/tb.sv
